FILE: hdl/fdts_pkg.sv
// Shared types and constants for the frame interval smoother.
// Used by fdts_median and the top level; depends on nothing.
package fdts_pkg;

  localparam int AVERAGE_DEPTH_DEF = 8;
  localparam int MEDIAN_DEPTH_DEF  = 100;
  localparam int DATA_W            = 32;
  localparam int PAUSE_W           = 8;

  localparam logic [PAUSE_W-1:0] PAUSE_MAX = 8'd255;

  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_STOP   = 2'd1;
  localparam logic [1:0] FUNC_START  = 2'd2;

  typedef enum logic [2:0] {
    TS_IDLE,
    TS_SUM,
    TS_DIV,
    TS_MED,
    TS_OUT
  } top_state_t;

  typedef enum logic [3:0] {
    MS_IDLE,
    MS_OLD_RD,
    MS_OLD_CK,
    MS_RM_RD,
    MS_RM_CK,
    MS_INS_RD,
    MS_INS_CK,
    MS_FIN,
    MS_OUT
  } med_state_t;

endpackage

FILE: hdl/fdts_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing beyond its parameters.
module fdts_divider #(
  parameter int NUM_W = 36,
  parameter int DEN_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem;
  logic [DEN_W:0]   trial;
  logic             fit;

  assign trial = {rem[DEN_W-1:0], quo[NUM_W-1]};
  assign fit   = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      rem <= fit ? (trial - {1'b0, den_r}) : trial;
      quo <= {quo[NUM_W-2:0], fit};
    end
  end

endmodule

FILE: hdl/fdts_median.sv
// Median window: a circular store of recent means and a sorted copy kept by
// an insertion pass per beat, after a removal pass once full. Uses fdts_pkg.
module fdts_median #(
  parameter int DEPTH = fdts_pkg::MEDIAN_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [fdts_pkg::DATA_W-1:0] value,
  output logic                        done,
  output logic [fdts_pkg::DATA_W-1:0] median
);
  import fdts_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  med_state_t state, state_next;

  logic [DATA_W-1:0] raw_mem  [DEPTH];
  logic [DATA_W-1:0] sort_mem [DEPTH];
  logic [DATA_W-1:0] raw_rd, sort_rd;
  logic [IDX_W-1:0]  sort_ra;
  logic              sort_we, raw_we;
  logic [IDX_W-1:0]  sort_wa;
  logic [DATA_W-1:0] sort_wd;

  logic [DATA_W-1:0] new_val, old_val;
  logic [CNT_W-1:0]  j, fill, fill_inc;
  logic [IDX_W-1:0]  slot;
  logic              found;

  assign fill_inc = (fill == CNT_W'(DEPTH)) ? fill : fill + 1'b1;

  always_ff @(posedge clk) begin
    if (sort_we) begin
      sort_mem[sort_wa] <= sort_wd;
    end
    if (raw_we) begin
      raw_mem[slot] <= new_val;
    end
    sort_rd <= sort_mem[sort_ra];
    raw_rd  <= raw_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    sort_ra    = j[IDX_W-1:0];
    sort_we    = 1'b0;
    sort_wa    = j[IDX_W-1:0];
    sort_wd    = new_val;
    raw_we     = 1'b0;
    done       = 1'b0;
    unique case (state)
      MS_IDLE: begin
        if (start) begin
          state_next = (fill == CNT_W'(DEPTH)) ? MS_OLD_RD : MS_INS_RD;
        end
      end
      MS_OLD_RD: state_next = MS_OLD_CK;
      MS_OLD_CK: state_next = MS_RM_RD;
      MS_RM_RD:  state_next = MS_RM_CK;
      MS_RM_CK: begin
        if (found) begin
          sort_we = 1'b1;
          sort_wa = IDX_W'(j - 1'b1);
          sort_wd = sort_rd;
        end
        state_next = (j == fill - 1'b1) ? MS_INS_RD : MS_RM_RD;
      end
      MS_INS_RD: begin
        sort_ra = IDX_W'(j - 1'b1);
        if (j == '0) begin
          sort_we    = 1'b1;
          state_next = MS_FIN;
        end else begin
          state_next = MS_INS_CK;
        end
      end
      MS_INS_CK: begin
        sort_we = 1'b1;
        if (sort_rd > new_val) begin
          sort_wd    = sort_rd;
          state_next = MS_INS_RD;
        end else begin
          state_next = MS_FIN;
        end
      end
      MS_FIN: begin
        raw_we     = 1'b1;
        sort_ra    = IDX_W'(fill_inc >> 1);
        state_next = MS_OUT;
      end
      MS_OUT: begin
        done       = 1'b1;
        state_next = MS_IDLE;
      end
      default: state_next = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      slot <= '0;
    end else if (state == MS_FIN) begin
      fill <= fill_inc;
      slot <= (slot == IDX_W'(DEPTH - 1)) ? '0 : slot + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      MS_IDLE: begin
        new_val <= value;
        j       <= fill;
        found   <= 1'b0;
      end
      MS_OLD_CK: begin
        old_val <= raw_rd;
        j       <= '0;
      end
      MS_RM_CK: begin
        if (!found && sort_rd == old_val) begin
          found <= 1'b1;
        end
        j <= (j == fill - 1'b1) ? fill - 1'b1 : j + 1'b1;
      end
      MS_INS_CK: begin
        if (sort_rd > new_val) begin
          j <= j - 1'b1;
        end
      end
      MS_OUT: median <= sort_rd;
      default: begin
      end
    endcase
  end

endmodule

FILE: hdl/frame_dt_smoother_top.sv
// Top level of the frame interval smoother: pause control, moving average,
// median window and output register. Uses fdts_pkg, fdts_divider and fdts_median.
//
// Input beats carry func and now_ticks under in_valid/in_stall; a sample
// beat yields one smoothed_interval beat under out_valid/out_stall, while
// stop and start beats yield none. The max_interval register is written
// through cfg_we/cfg_data only while the block is idle: the user is bound
// to this, and the block itself does not enforce it. A sample beat holds
// the input from its acceptance through the serial sum, the bit-serial
// divider and, once the median window is full, the two passes over the
// sorted median memory, which does one read and one write per element;
// before that only the insertion pass runs.
// in_stall stays high while a sample is in work. A finished result waits
// in the output register; a stalled receiver holds it and the block takes
// the next beat, but a further sample waits until the register is free.
// A synchronous reset sets the block paused with empty windows and
// max_interval all ones; no clearing pass is needed.
module frame_dt_smoother_top #(
  parameter int AVERAGE_DEPTH = fdts_pkg::AVERAGE_DEPTH_DEF,
  parameter int MEDIAN_DEPTH  = fdts_pkg::MEDIAN_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  func,
  input  logic [fdts_pkg::DATA_W-1:0] now_ticks,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fdts_pkg::DATA_W-1:0] smoothed_interval,
  input  logic                        cfg_we,
  input  logic [fdts_pkg::DATA_W-1:0] cfg_data
);
  import fdts_pkg::*;

  localparam int FILL_W = $clog2(AVERAGE_DEPTH + 1);
  localparam int SLOT_W = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
  localparam int SUM_W  = DATA_W + FILL_W;

  top_state_t state, state_next;

  logic [DATA_W-1:0]  max_interval;
  logic [DATA_W-1:0]  last_stamp, pause_stamp;
  logic [PAUSE_W-1:0] pause_depth;
  logic [DATA_W-1:0]  avg_win [AVERAGE_DEPTH];
  logic [FILL_W-1:0]  avg_fill, idx;
  logic [SLOT_W-1:0]  avg_slot;
  logic [SUM_W-1:0]   sum;
  logic [DATA_W-1:0]  interval, clamped;

  logic               accept, div_start, div_done, med_start, med_done;
  logic [SUM_W-1:0]   quo;
  logic [DATA_W-1:0]  median;
  logic               out_free;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign interval = (pause_depth != '0) ? pause_stamp - last_stamp : now_ticks - last_stamp;
  assign clamped  = (interval > max_interval) ? max_interval : interval;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    div_start  = 1'b0;
    med_start  = 1'b0;
    unique case (state)
      TS_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && func == FUNC_SAMPLE) begin
          state_next = TS_SUM;
        end
      end
      TS_SUM: begin
        if (idx == avg_fill - 1'b1) begin
          div_start  = 1'b1;
          state_next = TS_DIV;
        end
      end
      TS_DIV: begin
        if (div_done) begin
          med_start  = 1'b1;
          state_next = TS_MED;
        end
      end
      TS_MED: begin
        if (med_done) begin
          state_next = TS_OUT;
        end
      end
      TS_OUT: begin
        if (out_free) begin
          state_next = TS_IDLE;
        end
      end
      default: state_next = TS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_interval <= '1;
      last_stamp   <= '0;
      pause_stamp  <= '0;
      pause_depth  <= PAUSE_W'(1);
      avg_fill     <= '0;
      avg_slot     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_interval <= cfg_data;
      end
      if (accept) begin
        unique case (func)
          FUNC_SAMPLE: begin
            last_stamp <= (pause_depth != '0) ? pause_stamp : now_ticks;
            avg_slot   <= (avg_slot == SLOT_W'(AVERAGE_DEPTH - 1)) ? '0 : avg_slot + 1'b1;
            if (avg_fill != FILL_W'(AVERAGE_DEPTH)) begin
              avg_fill <= avg_fill + 1'b1;
            end
          end
          FUNC_STOP: begin
            if (pause_depth == '0) begin
              pause_stamp <= now_ticks;
            end
            if (pause_depth != PAUSE_MAX) begin
              pause_depth <= pause_depth + 1'b1;
            end
          end
          FUNC_START: begin
            if (pause_depth != '0) begin
              pause_depth <= pause_depth - 1'b1;
              if (pause_depth == PAUSE_W'(1)) begin
                last_stamp <= last_stamp + (now_ticks - pause_stamp);
              end
            end
          end
          default: begin
          end
        endcase
      end
      if (state == TS_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && func == FUNC_SAMPLE) begin
      avg_win[avg_slot] <= clamped;
      sum               <= '0;
      idx               <= '0;
    end else if (state == TS_SUM) begin
      sum <= sum + SUM_W'(avg_win[idx[SLOT_W-1:0]]);
      idx <= idx + 1'b1;
    end
    if (state == TS_OUT && out_free) begin
      smoothed_interval <= median;
    end
  end

  fdts_divider #(
    .NUM_W (SUM_W),
    .DEN_W (FILL_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (sum + SUM_W'(avg_win[idx[SLOT_W-1:0]])),
    .den   (avg_fill),
    .done  (div_done),
    .quo   (quo)
  );

  fdts_median #(
    .DEPTH (MEDIAN_DEPTH)
  ) u_med (
    .clk    (clk),
    .rst    (rst),
    .start  (med_start),
    .value  (quo[DATA_W-1:0]),
    .done   (med_done),
    .median (median)
  );

endmodule
